// ----- sv/tetm_pkg.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - shared package
// Field widths, register indexes, datapath commands, the statistics row
// layout and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package tetm_pkg;

   localparam int TASKS_DEFAULT = 8;

   localparam int TASK_W     = 3;
   localparam int SEC_W      = 17;
   localparam int NSEC_W     = 30;
   localparam int TIME_W     = 48;
   localparam int RUNS_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 30;

   // magnitude of a 49-bit signed difference
   localparam int DIVIDEND_W = TIME_W + 1;
   // wide enough for every sum that is later saturated
   localparam int SAT_W      = TIME_W + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_SECONDS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_NANOSECONDS = CSR_IDX_W'(1);

   localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);

   typedef logic signed [TIME_W-1:0] time_type;

   localparam time_type TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam time_type TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   typedef struct packed {
      time_type            start_stamp;
      time_type            worst_time;
      logic [RUNS_W-1:0]   runs;
      time_type            average_time;
      time_type            jitter_sum;
      time_type            jitter_average;
   } row_type;

   typedef struct packed {
      logic [TASK_W-1:0]   task_out;
      time_type            exec_time;
      time_type            worst_case;
      time_type            mean_exec;
      time_type            jitter_total;
      time_type            jitter_mean;
      logic [RUNS_W-1:0]   run_count;
   } result_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MULT,
      OP_LOAD,
      OP_RUN,
      OP_UPD,
      OP_JIT,
      OP_DIV_J,
      OP_DIV_A,
      OP_AVG,
      OP_FIN,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic task_ok;
      logic is_end;
      logic later_run;
      logic div_done;
   } status_type;

   function automatic time_type sat_time(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(TIME_MAX);
      lo = SAT_W'(TIME_MIN);
      if (v > hi) begin
         sat_time = TIME_MAX;
      end else if (v < lo) begin
         sat_time = TIME_MIN;
      end else begin
         sat_time = v[TIME_W-1:0];
      end
   endfunction

endpackage

// ----- sv/tetm_req_if.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - event channel
// Valid/ready channel carrying one start or end event per beat.
// ----------------------------------------------------------------------------
interface tetm_req_if;
   import tetm_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [TASK_W-1:0]   task_index;
   logic [SEC_W-1:0]    stamp_seconds;
   logic [NSEC_W-1:0]   stamp_nanoseconds;

   modport source (
      output valid, func, task_index, stamp_seconds, stamp_nanoseconds,
      input  ready
   );

   modport sink (
      input  valid, func, task_index, stamp_seconds, stamp_nanoseconds,
      output ready
   );

endinterface

// ----- sv/tetm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - statistics channel
// Valid/ready channel carrying one task's statistics per beat.
// ----------------------------------------------------------------------------
interface tetm_rsp_if;
   import tetm_pkg::*;

   logic                valid;
   logic                ready;
   logic [TASK_W-1:0]   task_out;
   time_type            exec_time;
   time_type            worst_case;
   time_type            mean_exec;
   time_type            jitter_total;
   time_type            jitter_mean;
   logic [RUNS_W-1:0]   run_count;

   modport source (
      output valid, task_out, exec_time, worst_case, mean_exec, jitter_total,
             jitter_mean, run_count,
      input  ready
   );

   modport sink (
      input  valid, task_out, exec_time, worst_case, mean_exec, jitter_total,
             jitter_mean, run_count,
      output ready
   );

endinterface

// ----- sv/tetm_ram.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tetm_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tetm_div.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - divider
// Unsigned restoring divider, one quotient bit per cycle, with a flag for a
// non-zero remainder. The result holds until the next start.
// ----------------------------------------------------------------------------
module tetm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tetm_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [tetm_pkg::RUNS_W-1:0]     divisor,
   output logic [tetm_pkg::DIVIDEND_W-1:0] quotient,
   output logic                            rem_nz,
   output logic                            done
);
   import tetm_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [RUNS_W-1:0]     rem_ff, rem_in;
   logic [RUNS_W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RUNS_W:0]       shifted;
   logic [RUNS_W:0]       trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = trial[RUNS_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[RUNS_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign rem_nz   = (rem_ff != '0);
   assign done     = done_ff;

endmodule

// ----- sv/tetm_dp.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - datapath
// Reference registers, elapsed time, the per-task statistics row (RAM plus
// valid bits), the update arithmetic, the shared divider and the result
// register. Each step is chosen by the controller's command.
// ----------------------------------------------------------------------------
module tetm_dp #(
   parameter int TASKS = tetm_pkg::TASKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_func,
   input  logic [tetm_pkg::TASK_W-1:0]     req_task_index,
   input  logic [tetm_pkg::SEC_W-1:0]      req_stamp_seconds,
   input  logic [tetm_pkg::NSEC_W-1:0]     req_stamp_nanoseconds,
   input  logic                            csr_we,
   input  logic [tetm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tetm_pkg::CSR_DATA_W-1:0] csr_data,
   input  tetm_pkg::cmd_type               cmd,
   output tetm_pkg::status_type            status,
   output tetm_pkg::result_type            result
);
   import tetm_pkg::*;

   localparam int ADDR_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int ROW_W  = $bits(row_type);

   logic [SEC_W-1:0]          ref_sec_ff, ref_sec_in;
   logic [NSEC_W-1:0]         ref_ns_ff, ref_ns_in;
   logic                      func_ff, func_in;
   logic [TASK_W-1:0]         idx_ff, idx_in;
   logic [SEC_W-1:0]          sec_ff, sec_in;
   logic [NSEC_W-1:0]         ns_ff, ns_in;
   time_type                  prod_ff, prod_in;
   logic signed [NSEC_W:0]    dn_ff, dn_in;
   time_type                  now_ff, now_in;
   row_type                   row_ff, row_in;
   time_type                  diff_ff, diff_in;
   logic signed [TIME_W:0]    d_ff, d_in;
   logic signed [TIME_W+1:0]  fq_ff, fq_in;
   logic [TASKS-1:0]          valid_ff, valid_in;
   result_type                result_ff, result_in;

   logic [ADDR_W-1:0]         addr;
   logic [ROW_W-1:0]          ram_rdata;
   row_type                   ram_row;
   row_type                   row_wr;
   logic                      ram_we;

   logic signed [SEC_W:0]     ds;
   logic signed [TIME_W:0]    prod_full;
   logic signed [TIME_W:0]    now_full;
   logic signed [TIME_W:0]    diff_full;
   logic signed [TIME_W:0]    d_full;
   logic signed [TIME_W+1:0]  js_full;
   logic signed [TIME_W:0]    js_ext;
   logic signed [TIME_W:0]    js_neg;
   logic signed [TIME_W:0]    d_neg;
   logic signed [TIME_W:0]    q_s;
   logic signed [TIME_W:0]    ja_full;
   logic signed [TIME_W+1:0]  q_w;
   logic signed [SAT_W-1:0]   sum0;
   logic signed [SAT_W-1:0]   sum1;

   logic                      div_start;
   logic [DIVIDEND_W-1:0]     div_dividend;
   logic [DIVIDEND_W-1:0]     div_quo;
   logic                      div_rnz;
   logic                      div_done;

   assign addr = ADDR_W'(idx_ff);

   tetm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (row_wr),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   tetm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (row_ff.runs),
      .quotient (div_quo),
      .rem_nz   (div_rnz),
      .done     (div_done)
   );

   // arithmetic between the working registers
   always_comb begin
      ram_row   = row_type'(ram_rdata);
      ds        = $signed({1'b0, sec_ff}) - $signed({1'b0, ref_sec_ff});
      prod_full = (TIME_W+1)'(ds) * (TIME_W+1)'($signed({1'b0, NS_PER_SEC}));
      now_full  = (TIME_W+1)'(prod_ff) + (TIME_W+1)'(dn_ff);
      diff_full = (TIME_W+1)'(now_ff) - (TIME_W+1)'($signed(row_ff.start_stamp));
      d_full    = (TIME_W+1)'(diff_ff) - (TIME_W+1)'($signed(row_ff.average_time));
      js_full   = (TIME_W+2)'($signed(row_ff.jitter_sum)) + (TIME_W+2)'(d_ff);
      js_ext    = (TIME_W+1)'($signed(row_ff.jitter_sum));
      js_neg    = -js_ext;
      d_neg     = -d_ff;
      q_s       = $signed(div_quo);
      ja_full   = js_ext[TIME_W] ? -q_s : q_s;
      q_w       = $signed({1'b0, div_quo});
      // fq_ff rounded a negative dividend with a remainder down; a negative sum with a remainder adds one back
      sum0      = SAT_W'($signed(row_ff.average_time)) + SAT_W'(fq_ff);
      sum1      = sum0 + SAT_W'(1);
   end

   always_comb begin
      div_start    = (cmd.op == OP_DIV_J) || (cmd.op == OP_DIV_A);
      div_dividend = '0;
      case (cmd.op)
         OP_DIV_J: div_dividend = js_ext[TIME_W] ? js_neg : js_ext;
         OP_DIV_A: div_dividend = d_ff[TIME_W] ? d_neg : d_ff;
         default:  div_dividend = '0;
      endcase
   end

   always_comb begin
      row_wr = row_ff;
      if (!func_ff) begin
         row_wr.start_stamp = now_ff;
      end
      ram_we = (cmd.op == OP_WRITE);
   end

   always_comb begin
      ref_sec_in = ref_sec_ff;
      ref_ns_in  = ref_ns_ff;
      func_in    = func_ff;
      idx_in     = idx_ff;
      sec_in     = sec_ff;
      ns_in      = ns_ff;
      prod_in    = prod_ff;
      dn_in      = dn_ff;
      now_in     = now_ff;
      row_in     = row_ff;
      diff_in    = diff_ff;
      d_in       = d_ff;
      fq_in      = fq_ff;
      valid_in   = valid_ff;
      result_in  = result_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_REF_SECONDS:     ref_sec_in = csr_data[SEC_W-1:0];
            CSR_REF_NANOSECONDS: ref_ns_in  = csr_data[NSEC_W-1:0];
            default:             ref_sec_in = ref_sec_ff;
         endcase
      end

      case (cmd.op)
         OP_CAPTURE: begin
            func_in = req_func;
            idx_in  = req_task_index;
            sec_in  = req_stamp_seconds;
            ns_in   = req_stamp_nanoseconds;
         end
         OP_MULT: begin
            prod_in = prod_full[TIME_W-1:0];
            dn_in   = $signed({1'b0, ns_ff}) - $signed({1'b0, ref_ns_ff});
         end
         OP_LOAD: begin
            now_in = now_full[TIME_W-1:0];
            row_in = valid_ff[addr] ? ram_row : '0;
         end
         OP_RUN: begin
            diff_in = sat_time(SAT_W'(diff_full));
         end
         OP_UPD: begin
            if ($signed(row_ff.worst_time) < diff_ff) begin
               row_in.worst_time = diff_ff;
            end
            if (row_ff.runs != '1) begin
               row_in.runs = row_ff.runs + 1'b1;
            end
            if (row_ff.runs == '0) begin
               row_in.average_time = diff_ff;
            end
            d_in = d_full;
         end
         OP_JIT: begin
            row_in.jitter_sum = sat_time(SAT_W'(js_full));
         end
         OP_DIV_A: begin
            // the jitter quotient is still held by the divider
            row_in.jitter_average = ja_full[TIME_W-1:0];
         end
         OP_AVG: begin
            if (d_ff[TIME_W]) begin
               fq_in = div_rnz ? ~q_w : -q_w;
            end else begin
               fq_in = q_w;
            end
         end
         OP_FIN: begin
            row_in.average_time = sat_time((sum0[SAT_W-1] && div_rnz) ? sum1 : sum0);
         end
         OP_WRITE: begin
            valid_in[addr] = 1'b1;
            if (cmd.emit) begin
               result_in.task_out     = idx_ff;
               result_in.exec_time    = diff_ff;
               result_in.worst_case   = row_ff.worst_time;
               result_in.mean_exec    = row_ff.average_time;
               result_in.jitter_total = row_ff.jitter_sum;
               result_in.jitter_mean  = row_ff.jitter_average;
               result_in.run_count    = row_ff.runs;
            end
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_sec_ff <= '0;
         ref_ns_ff  <= '0;
         valid_ff   <= '0;
      end else begin
         ref_sec_ff <= ref_sec_in;
         ref_ns_ff  <= ref_ns_in;
         valid_ff   <= valid_in;
      end
      func_ff   <= func_in;
      idx_ff    <= idx_in;
      sec_ff    <= sec_in;
      ns_ff     <= ns_in;
      prod_ff   <= prod_in;
      dn_ff     <= dn_in;
      now_ff    <= now_in;
      row_ff    <= row_in;
      diff_ff   <= diff_in;
      d_ff      <= d_in;
      fq_ff     <= fq_in;
      result_ff <= result_in;
   end

   assign status.task_ok   = (32'(idx_ff) < 32'(TASKS));
   assign status.is_end    = func_ff;
   assign status.later_run = (row_ff.runs != '0);
   assign status.div_done  = div_done;
   assign result           = result_ff;

endmodule

// ----- sv/tetm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - controller
// Sequences one event through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module tetm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tetm_pkg::cmd_type    cmd,
   input  tetm_pkg::status_type status
);
   import tetm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MULT,
      S_LOAD,
      S_RUN,
      S_UPD,
      S_JIT,
      S_DIVJ_GO,
      S_DIVJ_WAIT,
      S_DIVA_GO,
      S_DIVA_WAIT,
      S_AVG,
      S_FIN,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            cmd.op   = OP_MULT;
            // drop events for tasks beyond the table
            state_in = status.task_ok ? S_LOAD : S_IDLE;
         end
         S_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = status.is_end ? S_RUN : S_WRITE;
         end
         S_RUN: begin
            cmd.op   = OP_RUN;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op   = OP_UPD;
            state_in = status.later_run ? S_JIT : S_WRITE;
         end
         S_JIT: begin
            cmd.op   = OP_JIT;
            state_in = S_DIVJ_GO;
         end
         S_DIVJ_GO: begin
            cmd.op   = OP_DIV_J;
            state_in = S_DIVJ_WAIT;
         end
         S_DIVJ_WAIT: begin
            if (status.div_done) begin
               state_in = S_DIVA_GO;
            end
         end
         S_DIVA_GO: begin
            cmd.op   = OP_DIV_A;
            state_in = S_DIVA_WAIT;
         end
         S_DIVA_WAIT: begin
            if (status.div_done) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            cmd.op   = OP_AVG;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!status.is_end) begin
               cmd.op   = OP_WRITE;
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // hold until the result register is free
               cmd.op       = OP_WRITE;
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/task_execution_time_monitor.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - top level
// Per-task execution time, worst case, run count, running average and jitter
// statistics from timestamped start and end events.
// ----------------------------------------------------------------------------
// One event is handled at a time. A start event only records its time stamp
// in its row, and an event for a task beyond TASKS is dropped; the first end
// event of a task updates its row without dividing, and every later end event
// runs two 49-step divisions (jitter average, then running average) that
// share one bit-per-cycle divider. A result waits in an output register, so
// the next event is taken while it is still pending; an end event that finds
// that register still full holds in its last step until the statistics beat
// ahead of it is taken. The statistics of each task sit in one RAM row that
// is read, updated and written back; a row never written since reset reads
// as zero. The reference time is set through the csr port: index 0 seconds,
// index 1 nanoseconds.
// ----------------------------------------------------------------------------
module task_execution_time_monitor #(
   parameter int TASKS = tetm_pkg::TASKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tetm_req_if.sink                        req_bus,
   tetm_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [tetm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tetm_pkg::CSR_DATA_W-1:0] csr_data
);
   import tetm_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;

   tetm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tetm_dp #(
      .TASKS (TASKS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .req_func              (req_bus.func),
      .req_task_index        (req_bus.task_index),
      .req_stamp_seconds     (req_bus.stamp_seconds),
      .req_stamp_nanoseconds (req_bus.stamp_nanoseconds),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .cmd                   (cmd),
      .status                (status),
      .result                (result)
   );

   assign rsp_bus.task_out     = result.task_out;
   assign rsp_bus.exec_time    = result.exec_time;
   assign rsp_bus.worst_case   = result.worst_case;
   assign rsp_bus.mean_exec    = result.mean_exec;
   assign rsp_bus.jitter_total = result.jitter_total;
   assign rsp_bus.jitter_mean  = result.jitter_mean;
   assign rsp_bus.run_count    = result.run_count;

endmodule

// ----- sv/tetm_chk.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - port checker
// Checks over time what the statistics channel shows; bound to the top level.
// ----------------------------------------------------------------------------
module tetm_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tetm_pkg::TASK_W-1:0]     task_out,
   input logic signed [tetm_pkg::TIME_W-1:0] exec_time,
   input logic signed [tetm_pkg::TIME_W-1:0] worst_case,
   input logic signed [tetm_pkg::TIME_W-1:0] mean_exec,
   input logic signed [tetm_pkg::TIME_W-1:0] jitter_total,
   input logic signed [tetm_pkg::TIME_W-1:0] jitter_mean,
   input logic [tetm_pkg::RUNS_W-1:0]     run_count
);
   import tetm_pkg::*;

   // a stalled beat keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(task_out)
         && $stable(exec_time) && $stable(run_count))
      else $error("result beat changed while stalled");

   a_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> run_count != '0)
      else $error("result with zero run count");

   a_worst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> worst_case >= exec_time)
      else $error("worst case below this run");

   // the first run sets the average and leaves jitter untouched
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_count == RUNS_W'(1) |-> mean_exec == exec_time
         && jitter_total == '0 && jitter_mean == '0)
      else $error("first run statistics wrong");

endmodule

bind task_execution_time_monitor tetm_chk u_tetm_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .task_out     (rsp_bus.task_out),
   .exec_time    (rsp_bus.exec_time),
   .worst_case   (rsp_bus.worst_case),
   .mean_exec    (rsp_bus.mean_exec),
   .jitter_total (rsp_bus.jitter_total),
   .jitter_mean  (rsp_bus.jitter_mean),
   .run_count    (rsp_bus.run_count)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Task execution time monitor - testbench
// Drives timestamped start and end events through the event channel, keeps
// its own per-task statistics and checks every statistics beat against them.
// The reference time is changed between phases, with the channels idle, and
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import tetm_pkg::*;

   localparam logic    EV_START   = 1'b0;
   localparam logic    EV_END     = 1'b1;
   localparam int      NTASK      = TASKS_DEFAULT;
   localparam longint  NANOS      = 1000000000;
   localparam longint  SEC_TOP    = 131071;
   localparam longint  NS_TOP     = 1073741823;
   localparam longint  NS_LEGAL   = 999999999;
   localparam longint  STAMP_TOP  = SEC_TOP * NANOS + NS_LEGAL;
   localparam int      IDLE_LIMIT = 4000;
   localparam int      SETTLE     = 150;

   localparam logic signed [127:0] WIDE_MAX = 128'sd140737488355327;
   localparam logic signed [127:0] WIDE_MIN = -128'sd140737488355328;

   typedef struct packed {
      logic                func;
      logic [TASK_W-1:0]   task_id;
      logic [SEC_W-1:0]    sec;
      logic [NSEC_W-1:0]   nsec;
   } stamp_event_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   tetm_req_if req_bus ();
   tetm_rsp_if rsp_bus ();

   task_execution_time_monitor dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicted statistics, one entry per task
   logic [SEC_W-1:0]   ref_sec;
   logic [NSEC_W-1:0]  ref_nsec;
   time_type           lap_begin [NTASK];
   time_type           lap_worst [NTASK];
   logic [RUNS_W-1:0]  lap_runs  [NTASK];
   time_type           lap_mean  [NTASK];
   time_type           jit_sum   [NTASK];
   time_type           jit_mean  [NTASK];

   stamp_event_type pending_events [$];
   result_type      stats_due [$];
   int              events_sent;
   int              events_taken;
   int              error_count = 0;
   logic            req_took;

   // stimulus shaping per task
   bit     run_open   [NTASK];
   longint run_begin  [NTASK];
   longint run_typ    [NTASK];
   longint run_spread [NTASK];

   int burst_left;
   int gap_left;
   int stall_tick;
   int stall_mode;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic time_type clamp48(input logic signed [127:0] v);
      if (v > WIDE_MAX) begin
         return TIME_MAX;
      end else if (v < WIDE_MIN) begin
         return TIME_MIN;
      end else begin
         return v[TIME_W-1:0];
      end
   endfunction

   function automatic longint rand_between(input longint lo, input longint hi);
      return longint'($urandom_range(32'(hi), 32'(lo)));
   endfunction

   // update one task's statistics and queue the beat an end event yields
   task automatic account_event(input stamp_event_type ev);
      int                  t;
      longint              now_ns;
      time_type            lap;
      logic signed [127:0] n_w;
      logic signed [127:0] dev;
      logic signed [127:0] acc;
      result_type          r;
      t = int'(ev.task_id);
      now_ns = (longint'(ev.sec) - longint'(ref_sec)) * NANOS
             + (longint'(ev.nsec) - longint'(ref_nsec));
      if (ev.func == EV_START) begin
         lap_begin[t] = time_type'(now_ns);
      end else begin
         lap = clamp48(128'(now_ns - longint'(lap_begin[t])));
         if (lap_worst[t] < lap) lap_worst[t] = lap;
         if (lap_runs[t] != '1) lap_runs[t] = lap_runs[t] + RUNS_W'(1);
         if (lap_runs[t] > RUNS_W'(1)) begin
            n_w = {96'd0, lap_runs[t]};
            dev = 128'(lap) - 128'(lap_mean[t]);
            acc = 128'(jit_sum[t]) + dev;
            jit_sum[t] = clamp48(acc);
            acc = 128'(jit_sum[t]);
            acc = acc / n_w;
            jit_mean[t] = acc[TIME_W-1:0];
            acc = 128'(lap_mean[t]);
            acc = (acc * (n_w - 128'sd1) + 128'(lap)) / n_w;
            lap_mean[t] = clamp48(acc);
         end else begin
            lap_mean[t] = lap;
         end
         r.task_out     = ev.task_id;
         r.exec_time    = lap;
         r.worst_case   = lap_worst[t];
         r.mean_exec    = lap_mean[t];
         r.jitter_total = jit_sum[t];
         r.jitter_mean  = jit_mean[t];
         r.run_count    = lap_runs[t];
         stats_due = {stats_due, r};
      end
   endtask

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic push_event(input logic f, input int t, input longint s,
                             input longint ns);
      stamp_event_type ev;
      ev.func    = f;
      ev.task_id = TASK_W'(t);
      ev.sec     = SEC_W'(s);
      ev.nsec    = NSEC_W'(ns);
      pending_events = {pending_events, ev};
      events_sent++;
   endtask

   task automatic write_reference(input longint s, input longint ns);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_REF_SECONDS;
      csr_data  = CSR_DATA_W'(s);
      ref_sec   = SEC_W'(s);
      @(negedge clock);
      csr_index = CSR_REF_NANOSECONDS;
      csr_data  = CSR_DATA_W'(ns);
      ref_nsec  = NSEC_W'(ns);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // wait for every beat to go through, then let a trailing start event finish
   task automatic settle();
      while (events_taken != events_sent || stats_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic shape_runs();
      int t;
      for (t = 0; t < NTASK; t++) begin
         case ($urandom_range(0, 2))
            0:       run_typ[t] = rand_between(0, 2000);
            1:       run_typ[t] = rand_between(0, 1000000);
            default: run_typ[t] = rand_between(0, 2000000000);
         endcase
         run_spread[t] = rand_between(0, run_typ[t] / 8 + 10);
      end
   endtask

   // mostly start/end pairs per task with a typical run time; some noise,
   // repeated starts and ends that land far away
   task automatic add_random_phase(input int count);
      int     k;
      int     t;
      longint e;
      longint s;
      longint ns;
      for (k = 0; k < count; k++) begin
         t = $urandom_range(0, NTASK - 1);
         if ($urandom_range(0, 99) < 12) begin
            push_event(1'($urandom_range(0, 1)), t, rand_between(0, SEC_TOP),
                       rand_between(0, NS_TOP));
         end else if (run_open[t] && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 19) == 0) begin
               e = run_begin[t] + longint'($urandom_range(0, 32'd3000000000))
                 - 64'sd1500000000;
            end else begin
               e = run_begin[t] + run_typ[t] - run_spread[t]
                 + longint'($urandom_range(0, 32'(2 * run_spread[t])));
            end
            if (e < 0) e = 0;
            if (e > STAMP_TOP) e = STAMP_TOP;
            s  = e / NANOS;
            ns = e % NANOS;
            // borrow a second into the nanoseconds field now and then
            if ($urandom_range(0, 9) == 0 && s > 0 && ns + NANOS <= NS_TOP) begin
               s  = s - 1;
               ns = ns + NANOS;
            end
            push_event(EV_END, t, s, ns);
            run_open[t] = 1'b0;
         end else begin
            s  = rand_between(0, SEC_TOP);
            ns = ($urandom_range(0, 9) == 0) ? rand_between(0, NS_TOP)
                                              : rand_between(0, NS_LEGAL);
            push_event(EV_START, t, s, ns);
            run_begin[t] = s * NANOS + ns;
            run_open[t]  = 1'b1;
         end
      end
   endtask

   initial begin
      int p;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_REF_SECONDS;
      csr_data    = '0;
      ref_sec     = '0;
      ref_nsec    = '0;
      events_sent = 0;
      for (p = 0; p < NTASK; p++) begin
         lap_begin[p] = '0;
         lap_worst[p] = '0;
         lap_runs[p]  = '0;
         lap_mean[p]  = '0;
         jit_sum[p]   = '0;
         jit_mean[p]  = '0;
         run_open[p]  = 1'b0;
         run_begin[p] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // end with no start, second boundaries, negative and zero runs,
      // nanoseconds above one second
      write_reference(0, 0);
      push_event(EV_END,   0, 5, 100);
      push_event(EV_START, 1, 0, 0);
      push_event(EV_END,   1, 0, NS_LEGAL);
      push_event(EV_START, 1, 0, 1000);
      push_event(EV_END,   1, 1, 0);
      push_event(EV_START, 1, 2, 500);
      push_event(EV_END,   1, 2, 100);
      push_event(EV_START, 2, SEC_TOP, NS_TOP);
      push_event(EV_END,   2, SEC_TOP, NS_TOP);
      push_event(EV_START, 3, 0, NS_TOP);
      push_event(EV_END,   3, 1, 0);
      push_event(EV_START, 4, SEC_TOP, NS_TOP);
      push_event(EV_START, 6, 0, 0);
      push_event(EV_END,   6, 0, 1);
      settle();

      // move the reference so that runs spanning it saturate both ways
      write_reference(SEC_TOP, NS_LEGAL);
      push_event(EV_END,   4, 0, 0);
      push_event(EV_START, 4, 0, 0);
      push_event(EV_START, 5, 0, 0);
      push_event(EV_START, 7, SEC_TOP, NS_LEGAL);
      push_event(EV_END,   7, SEC_TOP, NS_LEGAL);
      settle();

      write_reference(0, 0);
      push_event(EV_END, 4, SEC_TOP, NS_TOP);
      push_event(EV_END, 5, SEC_TOP, NS_TOP);
      push_event(EV_END, 5, 0, 0);
      settle();

      for (p = 0; p < 5; p++) begin
         case (p)
            0:       write_reference(0, 0);
            1:       write_reference(SEC_TOP, NS_TOP);
            2:       write_reference(rand_between(0, SEC_TOP), rand_between(0, NS_LEGAL));
            3:       write_reference(rand_between(0, SEC_TOP), NS_LEGAL);
            default: write_reference(0, rand_between(0, NS_TOP));
         endcase
         shape_runs();
         add_random_phase(275);
         settle();
      end

      if (error_count == 0) begin
         $display("task_execution_time_monitor test passed");
      end else begin
         $display("task_execution_time_monitor test failed");
      end
      $finish;
   end

   // event driver: bursts of beats with random gaps between them
   always @(negedge clock) begin : drive_events
      stamp_event_type nxt;
      if (reset) begin
         req_bus.valid             <= 1'b0;
         req_bus.func              <= EV_START;
         req_bus.task_index        <= '0;
         req_bus.stamp_seconds     <= '0;
         req_bus.stamp_nanoseconds <= '0;
         burst_left                <= $urandom_range(1, 12);
         gap_left                  <= 0;
      end else if (!req_bus.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            nxt = pending_events.pop_front();
            req_bus.valid             <= 1'b1;
            req_bus.func              <= nxt.func;
            req_bus.task_index        <= nxt.task_id;
            req_bus.stamp_seconds     <= nxt.sec;
            req_bus.stamp_nanoseconds <= nxt.nsec;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150)
                                                         : $urandom_range(0, 3);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // statistics receiver: stall pattern is picked anew each time stall_tick wraps
   always @(negedge clock) begin
      if (stall_tick >= 599 || reset) begin
         stall_tick <= 0;
         stall_mode <= $urandom_range(0, 3);
      end else begin
         stall_tick <= stall_tick + 1;
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         2:       rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_bus.ready <= stall_tick[4];
      endcase
   end

   always @(posedge clock) begin : observe
      stamp_event_type ev;
      result_type      want;
      if (reset) begin
         req_took     <= 1'b0;
         events_taken <= 0;
      end else begin
         req_took <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            ev.func    = req_bus.func;
            ev.task_id = req_bus.task_index;
            ev.sec     = req_bus.stamp_seconds;
            ev.nsec    = req_bus.stamp_nanoseconds;
            account_event(ev);
            events_taken <= events_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (stats_due.size() == 0) begin
               flag_mismatch($sformatf("statistics beat for task %0d with none outstanding",
                                       rsp_bus.task_out));
            end else begin
               want = stats_due.pop_front();
               check_field("task_out",     64'(rsp_bus.task_out),     64'(want.task_out));
               check_field("exec_time",    64'(rsp_bus.exec_time),    64'(want.exec_time));
               check_field("worst_case",   64'(rsp_bus.worst_case),   64'(want.worst_case));
               check_field("mean_exec",    64'(rsp_bus.mean_exec),    64'(want.mean_exec));
               check_field("jitter_total", 64'(rsp_bus.jitter_total), 64'(want.jitter_total));
               check_field("jitter_mean",  64'(rsp_bus.jitter_mean),  64'(want.jitter_mean));
               check_field("run_count",    64'(rsp_bus.run_count),    64'(want.run_count));
            end
         end
      end
   end

   // drop out if nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("task_execution_time_monitor test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
